### design/dst_pkg.sv
// Shared types and codes for the descriptor slot table.
// Holds operation, status and controller state encodings plus the
// command/status structs between controller and datapath.
package dst_pkg;

  typedef enum logic [2:0] {
    OP_GET   = 3'd0,
    OP_ALLOC = 3'd1,
    OP_SET   = 3'd2,
    OP_FREE  = 3'd3,
    OP_DUP   = 3'd4,
    OP_DUP2  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BUSY  = 3'd1,
    ST_BADF  = 3'd2,
    ST_INVAL = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // capture request, issue table reads
    logic exec;     // decide, write back, load result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_blocked;  // result register full and receiver stalling
  } dp_sts_t;

endpackage

### design/descriptor_slot_table.sv
// Top level of the descriptor slot table (lowest-free handle allocator).
// Instantiates dst_ctrl and dst_dp; uses dst_pkg.
// Usage: the input channel (in_valid/in_stall) carries one request
//   transaction: op, slot, second_slot and handle. The result channel
//   (out_valid/out_stall) returns one transaction per request: status,
//   slot_out, handle_out and the handles whose reference counts go up
//   (acquire) and down (release). cfg_we/cfg_wdata write the table-ready
//   bit; write it only while idle.
// Timing: a request is taken in the idle state, which also reads the source and
//   destination entries from the handle memory. The execute step that follows runs the
//   lowest-free encode over the used map, decides the result, writes the
//   memory back and loads the result register. No new request is taken before
//   the previous one has executed; out_valid rises in the cycle after the
//   execute step. The next request is accepted while the previous result
//   still waits.
// Reset (rst_n, synchronous, active low): clear the used map, set
//   table-ready, drop any pending result. The handle memory is not cleared:
//   a slot whose used bit is clear reads as empty.
// Stall: while out_stall holds a result, hold the next request in its
//   execute step and stall the input until the result register frees.
module descriptor_slot_table
  import dst_pkg::*;
#(
  parameter int SLOTS        = 64,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_slot,
  input  logic [7:0]  in_second_slot,
  input  logic [15:0] in_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_slot_out,
  output logic [15:0] out_handle_out,
  output logic [15:0] out_acquire_handle,
  output logic [15:0] out_release_handle,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequence accept and execute
  dst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table storage, decision logic and result register
  dst_dp #(
    .SLOTS        (SLOTS),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_op),
    .in_slot            (in_slot),
    .in_second_slot     (in_second_slot),
    .in_handle          (in_handle),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_slot_out       (out_slot_out),
    .out_handle_out     (out_handle_out),
    .out_acquire_handle (out_acquire_handle),
    .out_release_handle (out_release_handle)
  );

endmodule

### design/dst_ctrl.sv
// Controller for the descriptor slot table.
// Two-state sequencer: take a request, then execute it once the result
// register can take a new transaction. Uses dst_pkg.
module dst_ctrl
  import dst_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      CS_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = CS_EXEC;
        end
      end
      CS_EXEC: begin
        // hold until the result register frees up
        if (!sts.out_blocked) begin
          cmd.exec  = 1'b1;
          state_nxt = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

endmodule

### design/dst_dp.sv
// Datapath for the descriptor slot table.
// Holds the handle memory, used bitmap, ready register, lowest-free
// encoder and the result register. Uses dst_pkg.
module dst_dp
  import dst_pkg::*;
#(
  parameter int SLOTS        = 64,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_slot,
  input  logic [7:0]  in_second_slot,
  input  logic [15:0] in_handle,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_slot_out,
  output logic [15:0] out_handle_out,
  output logic [15:0] out_acquire_handle,
  output logic [15:0] out_release_handle
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW = (HANDLE_WIDTH < 16) ? HANDLE_WIDTH : 16;
  localparam logic [7:0] SLOT_LIMIT = 8'(SLOTS);

  logic [SW-1:0] mem [SLOTS];

  logic [SLOTS-1:0] used_r;
  logic             ready_r;

  logic [2:0]    op_r;
  logic [7:0]    s_r, d_r;
  logic [SW-1:0] h_r, rd_s_r, rd_d_r;

  logic          out_valid_r;
  logic [2:0]    status_r;
  logic [7:0]    slot_out_r;
  logic [15:0]   hout_r, acq_r, rel_r;

  logic [SLOTS-1:0] free_v, low_v;
  logic [IW-1:0]    fidx;
  logic             full;
  logic             s_ok, d_ok;
  logic [SW-1:0]    hs, hd;

  status_t       st;
  logic [7:0]    so;
  logic [SW-1:0] ho, aq, rl;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [SW-1:0] wr_data;
  logic          u_set, u_clr;

  // capture request and read source/destination entries
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_op;
      s_r    <= in_slot;
      d_r    <= in_second_slot;
      h_r    <= SW'(in_handle);
      rd_s_r <= mem[IW'(in_slot)];
      rd_d_r <= mem[IW'(in_second_slot)];
    end
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // lowest clear used bit: isolate lowest set bit of the free vector
  always_comb begin
    free_v = ~used_r;
    low_v  = free_v & (~free_v + SLOTS'(1));
    full   = (free_v == '0);
    fidx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (low_v[i]) begin
        fidx = fidx | IW'(i);
      end
    end
  end

  // a clear used bit means the slot is empty
  always_comb begin
    s_ok = (s_r < SLOT_LIMIT);
    d_ok = (d_r < SLOT_LIMIT);
    hs   = (s_ok && used_r[IW'(s_r)]) ? rd_s_r : '0;
    hd   = (d_ok && used_r[IW'(d_r)]) ? rd_d_r : '0;
  end

  always_comb begin
    st      = ST_OK;
    so      = '0;
    ho      = '0;
    aq      = '0;
    rl      = '0;
    wr_en   = 1'b0;
    wr_idx  = fidx;
    wr_data = '0;
    u_set   = 1'b0;
    u_clr   = 1'b0;
    if (op_t'(op_r) == OP_DUP2 && s_r == d_r) begin
      so = d_r;
    end else if (!ready_r) begin
      st = ST_BUSY;
    end else begin
      unique case (op_r)
        OP_GET: begin
          if (!s_ok || hs == '0) begin
            st = ST_BADF;
          end else begin
            ho = hs;
            aq = hs;
          end
        end
        OP_ALLOC: begin
          if (full) begin
            st = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_data = h_r;
            u_set   = 1'b1;
            aq      = h_r;
            so      = 8'(fidx);
          end
        end
        OP_SET: begin
          if (!s_ok) begin
            st = ST_INVAL;
          end else begin
            rl      = hs;
            wr_en   = 1'b1;
            wr_idx  = IW'(s_r);
            wr_data = h_r;
            u_set   = 1'b1;
            aq      = h_r;
            so      = s_r;
          end
        end
        OP_FREE: begin
          if (!s_ok || hs == '0) begin
            st = ST_BADF;
          end else begin
            rl     = hs;
            wr_en  = 1'b1;
            wr_idx = IW'(s_r);
            u_clr  = 1'b1;
          end
        end
        OP_DUP: begin
          if (!s_ok || hs == '0) begin
            st = ST_BADF;
          end else if (full) begin
            st = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_data = hs;
            u_set   = 1'b1;
            aq      = hs;
            so      = 8'(fidx);
          end
        end
        OP_DUP2: begin
          if (!s_ok || !d_ok || hs == '0) begin
            st = ST_BADF;
          end else begin
            rl      = hd;
            wr_en   = 1'b1;
            wr_idx  = IW'(d_r);
            wr_data = hs;
            u_set   = 1'b1;
            aq      = hs;
            so      = d_r;
          end
        end
        default: begin
          st = ST_INVAL;
        end
      endcase
    end
    wr_en = wr_en & cmd.exec;
    u_set = u_set & cmd.exec;
    u_clr = u_clr & cmd.exec;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      ready_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ready_r <= cfg_wdata;
      end
      if (u_set) begin
        used_r[wr_idx] <= 1'b1;
      end else if (u_clr) begin
        used_r[wr_idx] <= 1'b0;
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r   <= st;
      slot_out_r <= so;
      hout_r     <= 16'(ho);
      acq_r      <= 16'(aq);
      rel_r      <= 16'(rl);
    end
  end

  assign sts.out_blocked   = out_valid_r & out_stall;
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_slot_out       = slot_out_r;
  assign out_handle_out     = hout_r;
  assign out_acquire_handle = acq_r;
  assign out_release_handle = rel_r;

endmodule

### tb/dst_reply_checker.sv
// Reply checker for the descriptor slot table: watches the request, reply and
// config ports, predicts every reply from its own copy of the table, compares.
// Depends on dst_pkg for the op and status codes.
module dst_reply_checker
  import dst_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_slot,
  input  logic [7:0]  in_second_slot,
  input  logic [15:0] in_handle,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [7:0]  out_slot_out,
  input  logic [15:0] out_handle_out,
  input  logic [15:0] out_acquire_handle,
  input  logic [15:0] out_release_handle,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          replies_checked
);

  typedef struct {
    status_t     status;
    logic [7:0]  slot;
    logic [15:0] handle;
    logic [15:0] acquire;
    logic [15:0] release_h;
  } slot_reply_t;

  logic [15:0]  held_handle [SLOTS];
  logic         slot_taken  [SLOTS];
  logic         ready_bit;
  slot_reply_t  replies_due [$];
  slot_reply_t  want;
  int           mismatches;
  int           checked;

  initial begin
    fail_count      = 0;
    pending         = 0;
    replies_checked = 0;
    mismatches      = 0;
    checked         = 0;
  end

  // Priority encode over the used bits; SLOTS means the table is full.
  function automatic int lowest_clear_slot();
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_taken[i]) return i;
    end
    return SLOTS;
  endfunction

  // Apply one request to the table copy and return the reply it earns.
  function automatic slot_reply_t apply_request(logic [2:0] op, logic [7:0] src,
                                                logic [7:0] dst, logic [15:0] h);
    slot_reply_t r;
    int          f;
    r.status    = ST_OK;
    r.slot      = '0;
    r.handle    = '0;
    r.acquire   = '0;
    r.release_h = '0;
    if (op == OP_DUP2 && src == dst) begin
      r.slot = dst;
    end else if (!ready_bit) begin
      r.status = ST_BUSY;
    end else begin
      case (op)
        OP_GET: begin
          if (src >= SLOTS || held_handle[src] == '0) r.status = ST_BADF;
          else begin
            r.handle  = held_handle[src];
            r.acquire = held_handle[src];
          end
        end
        OP_ALLOC: begin
          f = lowest_clear_slot();
          if (f >= SLOTS) r.status = ST_FULL;
          else begin
            held_handle[f] = h;
            slot_taken[f]  = 1'b1;
            r.acquire      = h;
            r.slot         = f[7:0];
          end
        end
        OP_SET: begin
          if (src >= SLOTS) r.status = ST_INVAL;
          else begin
            r.release_h      = held_handle[src];
            held_handle[src] = h;
            slot_taken[src]  = 1'b1;
            r.acquire        = h;
            r.slot           = src;
          end
        end
        OP_FREE: begin
          if (src >= SLOTS || held_handle[src] == '0) r.status = ST_BADF;
          else begin
            r.release_h      = held_handle[src];
            held_handle[src] = '0;
            slot_taken[src]  = 1'b0;
          end
        end
        OP_DUP: begin
          if (src >= SLOTS || held_handle[src] == '0) r.status = ST_BADF;
          else begin
            f = lowest_clear_slot();
            if (f >= SLOTS) r.status = ST_FULL;
            else begin
              held_handle[f] = held_handle[src];
              slot_taken[f]  = 1'b1;
              r.acquire      = held_handle[src];
              r.slot         = f[7:0];
            end
          end
        end
        OP_DUP2: begin
          if (src >= SLOTS || dst >= SLOTS || held_handle[src] == '0) r.status = ST_BADF;
          else begin
            r.release_h      = held_handle[dst];
            held_handle[dst] = held_handle[src];
            slot_taken[dst]  = 1'b1;
            r.acquire        = held_handle[src];
            r.slot           = dst;
          end
        end
        default: r.status = ST_INVAL;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("reply %0d %s: got %0h, predicted %0h",
                                checked, name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        held_handle[i] = '0;
        slot_taken[i]  = 1'b0;
      end
      ready_bit = 1'b1;
      replies_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          report_mismatch("reply arrived with no request outstanding");
        end else begin
          want = replies_due.pop_front();
          compare_field("status", 16'(out_status), 16'(want.status));
          compare_field("slot_out", 16'(out_slot_out), 16'(want.slot));
          compare_field("handle_out", out_handle_out, want.handle);
          compare_field("acquire_handle", out_acquire_handle, want.acquire);
          compare_field("release_handle", out_release_handle, want.release_h);
        end
        checked++;
      end
      if (in_valid && !in_stall)
        replies_due.push_back(apply_request(in_op, in_slot, in_second_slot, in_handle));
      if (cfg_we) ready_bit = cfg_wdata;
    end
    pending         <= replies_due.size();
    fail_count      <= mismatches;
    replies_checked <= checked;
  end

endmodule

### tb/tb_descriptor_slot_table.sv
// Testbench top for descriptor_slot_table: drives requests, config writes and
// reply stalls, and gives the verdict from dst_reply_checker's failure count.
// Depends on dst_pkg, descriptor_slot_table and dst_reply_checker.
module tb_descriptor_slot_table
  import dst_pkg::*;
();

  localparam int SLOTS       = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 10;
  localparam int BUSY_PHASE  = 4;   // phase run with the table not ready
  localparam int CALM_PHASE  = 6;   // phase with no idling on either side

  // Op codes the block must reject as invalid.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op          = '0;
  logic [7:0]  in_slot        = '0;
  logic [7:0]  in_second_slot = '0;
  logic [15:0] in_handle      = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_slot_out;
  logic [15:0] out_handle_out;
  logic [15:0] out_acquire_handle;
  logic [15:0] out_release_handle;
  logic        cfg_we         = 1'b0;
  logic        cfg_wdata      = 1'b0;

  int  fail_count;
  int  pending;
  int  replies_checked;
  int  requests_sent  = 0;
  int  ready_writes   = 0;
  int  cycle_count    = 0;
  bit  calm           = 1'b0;

  descriptor_slot_table #(
    .SLOTS        (SLOTS),
    .HANDLE_WIDTH (16)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_slot            (in_slot),
    .in_second_slot     (in_second_slot),
    .in_handle          (in_handle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_slot_out       (out_slot_out),
    .out_handle_out     (out_handle_out),
    .out_acquire_handle (out_acquire_handle),
    .out_release_handle (out_release_handle),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  dst_reply_checker #(
    .SLOTS (SLOTS)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_slot            (in_slot),
    .in_second_slot     (in_second_slot),
    .in_handle          (in_handle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_slot_out       (out_slot_out),
    .out_handle_out     (out_handle_out),
    .out_acquire_handle (out_acquire_handle),
    .out_release_handle (out_release_handle),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .pending            (pending),
    .replies_checked    (replies_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the reply side at random, about 27 draws in 100; hold it open during the calm phase.
  always @(posedge clk) begin
    if (calm) out_stall <= 1'b0;
    else      out_stall <= ($urandom_range(99) < 27);
  end

  // Watchdog: end the run as failed if the table never drains.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
      $display("descriptor_slot_table: mismatch");
      $finish;
    end
  end

  // Offer one request transaction and hold it until accepted, then idle at random outside the calm phase.
  // Valid stays high on return unless it idled, so back-to-back requests do not toggle it.
  task automatic push_request(input logic [2:0] op, input logic [7:0] src,
                              input logic [7:0] dst, input logic [15:0] h);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_slot        <= src;
    in_second_slot <= dst;
    in_handle      <= h;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    if (!calm) begin
      while ($urandom_range(99) < 27) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait until every predicted reply has come back.
  task automatic settle_table();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write table_ready only with the block idle; wait on past the last reply before writing.
  task automatic write_ready(input logic value);
    settle_table();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ready_writes++;
  endtask

  // One random request. Fill mode leans on allocate and dup so the table hits full;
  // drain mode leans on free so it empties again and bad-descriptor paths show up.
  task automatic push_random(input bit drain_mode);
    int          pick;
    int          hpick;
    logic [2:0]  op;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [15:0] h;
    pick = $urandom_range(99);
    if (pick >= 96)
      op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
    else if (!drain_mode)
      op = (pick < 30) ? OP_ALLOC : (pick < 50) ? OP_DUP : (pick < 62) ? OP_SET :
           (pick < 74) ? OP_DUP2  : (pick < 88) ? OP_GET : OP_FREE;
    else
      op = (pick < 8)  ? OP_ALLOC : (pick < 14) ? OP_DUP : (pick < 20) ? OP_SET :
           (pick < 28) ? OP_DUP2  : (pick < 44) ? OP_GET : OP_FREE;
    // Keep most slots in range; the rest reach every bit of the 8-bit field.
    src = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(SLOTS - 1));
    dst = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(SLOTS - 1));
    if ($urandom_range(9) == 0) dst = src;
    hpick = $urandom_range(99);
    h = (hpick < 8) ? 16'h0000 : (hpick < 13) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
    push_request(op, src, dst, h);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, allocate extremes, range limits, equal dup2, unknown ops.
    write_ready(1'b1);
    push_request(OP_GET,   8'd0,   8'd0,   16'h0000);  // empty slot
    push_request(OP_FREE,  8'd63,  8'd0,   16'h0000);  // empty slot
    push_request(OP_ALLOC, 8'd0,   8'd0,   16'hFFFF);  // lands in slot 0
    push_request(OP_ALLOC, 8'd0,   8'd0,   16'h0000);  // used but empty slot 1
    push_request(OP_GET,   8'd1,   8'd0,   16'h0000);  // used yet empty reads as bad
    push_request(OP_SET,   8'd255, 8'd0,   16'h0001);  // out of range
    push_request(OP_SET,   8'd64,  8'd0,   16'h0001);  // first slot past the table
    push_request(OP_SET,   8'd63,  8'd0,   16'h8000);  // top slot
    push_request(OP_GET,   8'd0,   8'd0,   16'h0000);
    push_request(OP_DUP,   8'd0,   8'd0,   16'h0000);  // lowest free is slot 2
    push_request(OP_DUP,   8'd1,   8'd0,   16'h0000);  // empty source
    push_request(OP_DUP2,  8'd0,   8'd63,  16'h0000);  // releases the old top handle
    push_request(OP_DUP2,  8'd63,  8'd63,  16'h0000);  // equal slots
    push_request(OP_DUP2,  8'd255, 8'd255, 16'h0000);  // equal slots out of range
    push_request(OP_DUP2,  8'd200, 8'd3,   16'h0000);  // source out of range
    push_request(OP_DUP2,  8'd0,   8'd200, 16'h0000);  // destination out of range
    push_request(OP_SET,   8'd1,   8'd0,   16'h1234);  // fill the empty used slot
    push_request(OP_SET,   8'd0,   8'd0,   16'hFFFF);  // release and acquire same handle
    push_request(OP_FREE,  8'd2,   8'd0,   16'h0000);
    push_request(OP_SPARE_6, 8'd0, 8'd0,   16'h0000);
    push_request(OP_SPARE_7, 8'd0, 8'd0,   16'h0000);
    push_request(OP_ALLOC, 8'd0,   8'd0,   16'h5555);  // reuses slot 2

    // Table not ready: busy everywhere except the equal-slot dup2.
    write_ready(1'b0);
    push_request(OP_GET,   8'd0,   8'd0,   16'h0000);
    push_request(OP_DUP2,  8'd7,   8'd7,   16'h0000);
    push_request(OP_SPARE_7, 8'd0, 8'd0,   16'h0000);
    push_request(OP_DUP2,  8'd1,   8'd2,   16'h0000);

    // Random phases: alternate fill and drain, one busy phase, one calm phase.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_ready(ph != BUSY_PHASE);
      calm = (ph == CALM_PHASE);
      for (int n = 0; n < ((ph == BUSY_PHASE) ? 40 : 155); n++)
        push_random(ph[0]);
    end
    calm = 1'b0;

    // Drain the last replies and give the pipeline time to show any extra one.
    settle_table();
    repeat (8) @(posedge clk);

    $display("covered %0d requests and %0d replies over fill, drain and busy phases",
             requests_sent, replies_checked);
    $display("table_ready written %0d times, both values, with %0d reply errors",
             ready_writes, fail_count);
    if (fail_count == 0) begin
      $display("descriptor_slot_table: match");
    end else begin
      $display("descriptor_slot_table: mismatch");
    end
    $finish;
  end

endmodule

### files.f
design/dst_pkg.sv
design/dst_ctrl.sv
design/dst_dp.sv
design/descriptor_slot_table.sv
tb/dst_reply_checker.sv
tb/tb_descriptor_slot_table.sv
